// File: hw/rtl/sbir_pkg.sv
// Shared types and constants for the sorted bucket insert/remove unit.
// No dependencies; imported by sbir_cell and sorted_bucket_insert_remove_unit.
package sbir_pkg;

    localparam int KEY_W           = 32;
    localparam int CAP_W           = 5;
    localparam int CNT_OUT_W       = 5;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;

    // Command codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Input beat
    typedef struct packed {
        logic                     opcode;
        logic signed [KEY_W-1:0]  key;
    } in_t;

    // Result beat
    typedef struct packed {
        logic                  accepted;
        logic [CNT_OUT_W-1:0]  entry_count;
    } out_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                     compare;
        logic                     shift_ins;
        logic                     shift_rem;
        logic signed [KEY_W-1:0]  key;
    } cell_ctl_t;

endpackage

// File: hw/rtl/sorted_bucket_insert_remove_unit.sv
// Top level of the sorted bucket insert/remove unit: sequencer, count and
// capacity registers around a chain of sbir_cell slots. Depends on sbir_pkg.
//
// Usage:
//   Command channel: drive cmd and raise start; the beat is taken on a rising
//   edge with start high and busy low. opcode OP_INSERT places key in front of
//   the first stored key that is not smaller; OP_REMOVE deletes the first
//   stored key equal to key.
//   Result channel: done is high for one cycle with result valid (accepted
//   flag and entry count after the step). The receiver cannot stall it.
//   Configuration: cfg_data is written to the capacity register on an edge
//   with cfg_valid and cfg_ready high; cfg_ready is high while idle.
//   Sequence: after the accepting edge, a compare state in which every cell
//   compares its key in parallel, then a shift state in which the chain
//   shifts; done is registered from the shift state and stays high for one
//   result cycle. A new command is taken in the result cycle, not before the
//   previous command has completed its compare/shift sequence.
//   Reset: the key count clears to zero and capacity returns to 16; the slot
//   contents are not cleared, slots above the count are never consulted.
module sorted_bucket_insert_remove_unit #(
    parameter int MAX_ENTRIES = sbir_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sbir_pkg::in_t               cmd,
    output logic                        done,
    output sbir_pkg::out_t              result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sbir_pkg::CAP_W-1:0]  cfg_data
);
    import sbir_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CMP   = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CAP_W-1:0]        capacity_reg;
    logic                    op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic                    done_reg;
    out_t                    result_reg;
    out_t                    result_next;

    cell_ctl_t               ctl;
    logic                    full;
    logic                    found;
    logic                    ins_ok;
    logic                    rem_ok;

    logic signed [KEY_W-1:0] key_vec  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  less_vec;
    logic [MAX_ENTRIES-1:0]  eq_vec;

    // Decide the outcome from the registered compare flags
    always_comb
    begin
        full   = (CMP_W'(count_reg) >= CMP_W'(capacity_reg))
              || (count_reg >= CNT_W'(MAX_ENTRIES));
        found  = |eq_vec;
        ins_ok = (state_reg == ST_APPLY) && (op_reg == OP_INSERT) && !full;
        rem_ok = (state_reg == ST_APPLY) && (op_reg == OP_REMOVE) && found;

        ctl.compare   = (state_reg == ST_CMP);
        ctl.shift_ins = ins_ok;
        ctl.shift_rem = rem_ok;
        ctl.key       = key_reg;
    end

    // Advance the sequencer and the count
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
                if (ins_ok)
                begin
                    count_next = count_reg + 1'b1;
                end
                else if (rem_ok)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        result_next.accepted    = ins_ok || rem_ok;
        result_next.entry_count = CNT_OUT_W'(count_next);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            capacity_reg <= CAPACITY_RST;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == ST_APPLY);
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // Capture the command beat and the result beat
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg  <= cmd.opcode;
            key_reg <= cmd.key;
        end
        if (state_reg == ST_APPLY)
        begin
            result_reg <= result_next;
        end
    end

    // Chain of slots, each wired to its neighbors
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] lkey;
        logic                    lless;
        logic signed [KEY_W-1:0] rkey;
        logic                    use_slot;

        if (i == 0)
        begin : g_first
            assign lkey  = key_reg;
            assign lless = 1'b1;
        end
        else
        begin : g_mid
            assign lkey  = key_vec[i-1];
            assign lless = less_vec[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign rkey = key_vec[i];
        end
        else
        begin : g_inner
            assign rkey = key_vec[i+1];
        end

        assign use_slot = (CNT_W'(i) < count_reg);

        sbir_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .in_use    (use_slot),
            .left_key  (lkey),
            .left_less (lless),
            .right_key (rkey),
            .key_out   (key_vec[i]),
            .less_out  (less_vec[i]),
            .eq_out    (eq_vec[i])
        );
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign result    = result_reg;

`ifndef SYNTHESIS
    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_APPLY)
        else $error("done without a shift cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("key count above slot count");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.accepted && (op_reg == OP_INSERT)
        |-> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not bump count");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.accepted && (op_reg == OP_REMOVE)
        |-> count_reg == $past(count_reg) - 1'b1)
        else $error("accepted remove did not drop count");

    a_refused_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.accepted |-> count_reg == $past(count_reg))
        else $error("refused command changed count");
`endif

endmodule

// File: hw/rtl/sbir_cell.sv
// One slot of the sorted key chain: holds a key, compares it with the broadcast
// key and shifts to or from its neighbors. Depends on sbir_pkg.
module sbir_cell (
    input  logic                              clk,
    input  sbir_pkg::cell_ctl_t               ctl,
    input  logic                              in_use,
    input  logic signed [sbir_pkg::KEY_W-1:0] left_key,
    input  logic                              left_less,
    input  logic signed [sbir_pkg::KEY_W-1:0] right_key,
    output logic signed [sbir_pkg::KEY_W-1:0] key_out,
    output logic                              less_out,
    output logic                              eq_out
);
    import sbir_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    less_reg;
    logic                    eq_reg;

    // Pick the new slot content for an insert or remove shift
    always_comb
    begin
        key_next = key_reg;
        if (ctl.shift_ins)
        begin
            if (!less_reg)
            begin
                key_next = left_less ? ctl.key : left_key;
            end
        end
        else if (ctl.shift_rem)
        begin
            if (!less_reg)
            begin
                key_next = right_key;
            end
        end
    end

    // Hold the key and the compare flags; no reset on payload
    always_ff @(posedge clk)
    begin
        if (ctl.compare)
        begin
            less_reg <= in_use && (key_reg < ctl.key);
            eq_reg   <= in_use && (key_reg == ctl.key);
        end
        key_reg <= key_next;
    end

    assign key_out  = key_reg;
    assign less_out = less_reg;
    assign eq_out   = eq_reg;

endmodule
